// ----- hw/rtl/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam int WORDS  = 16;
	localparam int ADDR_W = 4;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] chain_t;
	typedef logic [ADDR_W-1:0] waddr_t;
	typedef logic [5:0] rnd_t;

	localparam word_t IV_A = 32'h67452301;
	localparam word_t IV_B = 32'hefcdab89;
	localparam word_t IV_C = 32'h98badcfe;
	localparam word_t IV_D = 32'h10325476;

	localparam word_t K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       is_last;
	} md5_msg_t;

	typedef struct packed {
		logic [63:0] digest_half;
		logic        half_index;
		logic        last_half;
	} md5_dig_t;

	typedef struct packed {
		logic load;
		logic step;
		logic fold;
		logic reinit;
	} rnd_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_ROUND,
		ST_FOLD,
		ST_OUT0,
		ST_OUT1
	} md5_state_t;

	typedef enum logic [1:0] {
		BLK_DATA,
		BLK_PAD,
		BLK_LEN
	} blk_kind_t;

	// message word index used by a round
	function automatic waddr_t msg_idx(input rnd_t r);
		waddr_t i;
		i = r[3:0];
		unique case (r[5:4])
			2'd0: msg_idx = i;
			2'd1: msg_idx = waddr_t'((i << 2) + i + 4'd1);
			2'd2: msg_idx = waddr_t'((i << 1) + i + 4'd5);
			2'd3: msg_idx = waddr_t'((i << 3) - i);
		endcase
	endfunction

	function automatic word_t bswap32(input word_t w);
		bswap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

// ----- hw/rtl/md5_msg_if.sv -----
// ----------------------------------------------------------------------------
// md5_msg_if
// Message byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface md5_msg_if;
	import md5_pkg::*;

	logic     valid;
	logic     ready;
	md5_msg_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/md5_dig_if.sv -----
// ----------------------------------------------------------------------------
// md5_dig_if
// Digest half channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface md5_dig_if;
	import md5_pkg::*;

	logic     valid;
	logic     ready;
	md5_dig_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/md5_buf_ram.sv -----
// ----------------------------------------------------------------------------
// md5_buf_ram
// Block buffer: 16 x 32-bit words, one write port, one registered read port.
// ----------------------------------------------------------------------------
module md5_buf_ram (
	input  logic           clk,
	input  logic           we,
	input  md5_pkg::waddr_t waddr,
	input  md5_pkg::word_t  wdata,
	input  md5_pkg::waddr_t raddr,
	output md5_pkg::word_t  rdata
);
	import md5_pkg::*;

	word_t mem [WORDS];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- hw/rtl/md5_round.sv -----
// ----------------------------------------------------------------------------
// md5_round
// One MD5 step per cycle while ctl.step is high, on the working words, plus the chaining words.
// ----------------------------------------------------------------------------
module md5_round (
	input  logic              clk,
	input  logic              arst_n,
	input  md5_pkg::rnd_ctl_t ctl,
	input  md5_pkg::rnd_t     rnd,
	input  md5_pkg::word_t    w,
	output md5_pkg::chain_t   chain
);
	import md5_pkg::*;

	word_t       a_q, b_q, c_q, d_q;
	chain_t      h_q;
	word_t       f;
	word_t       t;
	logic [63:0] rot_wide;
	word_t       b_next;

	always_comb begin
		unique case (rnd[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
		endcase
		t        = a_q + f + K_TAB[rnd] + w;
		rot_wide = {t, t} << ROT_TAB[{rnd[5:4], rnd[1:0]}];
		b_next   = b_q + rot_wide[63:32];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
		end else if (ctl.step) begin
			a_q <= d_q;
			b_q <= b_next;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= {IV_D, IV_C, IV_B, IV_A};
		end else if (ctl.reinit) begin
			h_q <= {IV_D, IV_C, IV_B, IV_A};
		end else if (ctl.fold) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
		end
	end

	assign chain = h_q;
endmodule

// ----- hw/rtl/md5_digest_engine.sv -----
// ----------------------------------------------------------------------------
// md5_digest_engine
// MD5 (RFC 1321) over a byte stream, digest given as two 64-bit halves.
// ----------------------------------------------------------------------------
// msg carries one byte per word with byte_valid and is_last; digest carries
// the 16 digest bytes as two words, first byte in the top bits of half 0.
// A byte that does not fill a 64-byte block is taken while the block stays
// idle. The block buffer sits in a 16 x 32 synchronous RAM; once 64 bytes
// are there, the compression reads one message word per cycle and runs one
// step per cycle: a priming state, 64 steps and a fold state per block, with
// msg.ready low meanwhile. A word with is_last pads the message and runs one
// or two more blocks (two when 56 or more bytes sit in the last block, or
// when the last byte itself fills a block), then offers the two digest words.
// Each digest word waits for digest.ready as long as needed; msg stays
// stalled until the second is taken, then chaining values and bit count
// return to their initial values. Reset clears the bit count, loads the
// initial chaining values and leaves the block idle and ready.
// ----------------------------------------------------------------------------
module md5_digest_engine (
	input logic        clk,
	input logic        arst_n,
	md5_msg_if.sink    msg,
	md5_dig_if.source  digest
);
	import md5_pkg::*;

	md5_state_t  state_q, state_d;
	blk_kind_t   blk_q;
	logic        fin_q;
	rnd_t        rnd_q;
	logic [63:0] count_q;
	logic [23:0] asm_q;
	waddr_t      g_s1;

	logic        accept;
	logic        full;
	logic        len_ok;
	waddr_t      nw;
	logic [1:0]  nb;
	logic        we;
	waddr_t      raddr;
	word_t       rdata;
	word_t       partial;
	word_t       w;
	rnd_ctl_t    ctl;
	chain_t      chain;

	assign accept = msg.valid && msg.ready;
	assign nw     = count_q[8:5];
	assign nb     = count_q[4:3];
	assign full   = msg.data.byte_valid && (count_q[8:3] == 6'h3F);
	assign len_ok = count_q[8:6] != 3'b111;
	assign we     = accept && msg.data.byte_valid && (nb == 2'd3);

	md5_buf_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (nw),
		.wdata ({msg.data.data_byte, asm_q}),
		.raddr (raddr),
		.rdata (rdata)
	);

	md5_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rnd    (rnd_q),
		.w      (w),
		.chain  (chain)
	);

	// partial word with the 0x80 marker
	always_comb begin
		unique case (nb)
			2'd0: partial = 32'h0000_0080;
			2'd1: partial = {16'h0000, 8'h80, asm_q[7:0]};
			2'd2: partial = {8'h00, 8'h80, asm_q[15:0]};
			2'd3: partial = {8'h80, asm_q[23:0]};
		endcase
	end

	always_comb begin
		w = '0;
		unique case (blk_q)
			BLK_DATA: w = rdata;
			BLK_PAD: begin
				priority if (g_s1 < nw) begin
					w = rdata;
				end else if (g_s1 == nw) begin
					w = partial;
				end else if (len_ok && g_s1 == 4'd14) begin
					w = count_q[31:0];
				end else if (len_ok && g_s1 == 4'd15) begin
					w = count_q[63:32];
				end else begin
					w = '0;
				end
			end
			BLK_LEN: begin
				if (g_s1 == 4'd14) begin
					w = count_q[31:0];
				end else if (g_s1 == 4'd15) begin
					w = count_q[63:32];
				end
			end
			default: w = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (full || msg.data.is_last)) begin
					state_d = ST_PRIME;
				end
			end
			ST_PRIME: state_d = ST_ROUND;
			ST_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				priority if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (blk_q == BLK_DATA || (blk_q == BLK_PAD && !len_ok)) begin
					state_d = ST_PRIME;
				end else begin
					state_d = ST_OUT0;
				end
			end
			ST_OUT0: begin
				if (digest.ready) begin
					state_d = ST_OUT1;
				end
			end
			ST_OUT1: begin
				if (digest.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		msg.ready    = 1'b0;
		digest.valid = 1'b0;
		ctl          = '0;
		raddr        = msg_idx(6'd0);
		unique case (state_q)
			ST_IDLE: msg.ready = 1'b1;
			ST_PRIME: ctl.load = 1'b1;
			ST_ROUND: begin
				ctl.step = 1'b1;
				raddr    = msg_idx(rnd_t'(rnd_q + 6'd1));
			end
			ST_FOLD: ctl.fold = 1'b1;
			ST_OUT0: digest.valid = 1'b1;
			ST_OUT1: begin
				digest.valid = 1'b1;
				ctl.reinit   = digest.ready;
			end
			default: ;
		endcase
	end

	assign digest.data.half_index  = (state_q == ST_OUT1);
	assign digest.data.last_half   = (state_q == ST_OUT1);
	assign digest.data.digest_half = (state_q == ST_OUT1)
		? {bswap32(chain[2]), bswap32(chain[3])}
		: {bswap32(chain[0]), bswap32(chain[1])};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			blk_q   <= BLK_DATA;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fin_q <= msg.data.is_last;
				blk_q <= full ? BLK_DATA : BLK_PAD;
				if (msg.data.byte_valid) begin
					count_q <= count_q + 64'd8;
				end
			end
			if (state_q == ST_FOLD && fin_q) begin
				blk_q <= (blk_q == BLK_DATA) ? BLK_PAD : BLK_LEN;
			end
			if (state_q == ST_PRIME) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_t'(rnd_q + 6'd1);
			end
			if (ctl.reinit) begin
				count_q <= '0;
			end
		end
	end

	// partial word assembly
	always_ff @(posedge clk) begin
		if (accept && msg.data.byte_valid) begin
			unique case (nb)
				2'd0: asm_q[7:0]   <= msg.data.data_byte;
				2'd1: asm_q[15:8]  <= msg.data.data_byte;
				2'd2: asm_q[23:16] <= msg.data.data_byte;
				2'd3: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		g_s1 <= raddr;
	end

	a_ready_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		msg.ready |-> !digest.valid)
		else $error("msg ready while digest pending");

	a_fold_after_63: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FOLD |-> $past(rnd_q) == 6'd63)
		else $error("fold without full round count");

	a_half_order: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && digest.ready && !digest.data.last_half |=> state_q == ST_OUT1)
		else $error("second digest half not next");

	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && digest.ready && digest.data.last_half
		|=> count_q == 64'd0 && state_q == ST_IDLE)
		else $error("no reinit after digest");
endmodule
